FILE: hdl/lcib_pkg.sv
package lcib_pkg;

  localparam int LINE_CAPACITY_DEF = 64;

  localparam logic [15:0] PERIOD_RESET = 16'd200;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_O     = 8'h4f;
  localparam logic [7:0] CH_N     = 8'h4e;
  localparam logic [7:0] CH_F     = 8'h46;

  localparam logic [30:0] NUM_MAX = 31'h7fff_ffff;

  // response codes
  localparam logic [3:0] RESP_NONE        = 4'd0;
  localparam logic [3:0] RESP_LED_ON      = 4'd1;
  localparam logic [3:0] RESP_LED_OFF     = 4'd2;
  localparam logic [3:0] RESP_LED_MISSING = 4'd3;
  localparam logic [3:0] RESP_LED_BAD     = 4'd4;
  localparam logic [3:0] RESP_BLK_MISSING = 4'd5;
  localparam logic [3:0] RESP_BLK_BAD     = 4'd6;
  localparam logic [3:0] RESP_BLK_START   = 4'd7;
  localparam logic [3:0] RESP_STATUS_ON   = 4'd8;
  localparam logic [3:0] RESP_STATUS_OFF  = 4'd9;
  localparam logic [3:0] RESP_HELP        = 4'd10;
  localparam logic [3:0] RESP_UNKNOWN     = 4'd11;
  localparam logic [3:0] RESP_TOO_LONG    = 4'd12;
  localparam logic [3:0] RESP_BLK_DONE    = 4'd13;

  // command word indexes
  localparam logic [1:0] WORD_LED    = 2'd0;
  localparam logic [1:0] WORD_BLINK  = 2'd1;
  localparam logic [1:0] WORD_STATUS = 2'd2;
  localparam logic [1:0] WORD_HELP   = 2'd3;

  // command matcher: {word, matched length}, plus two reserved codes
  localparam logic [4:0] CM_START = 5'd0;
  localparam logic [4:0] CM_FAIL  = 5'd31;

  typedef struct packed {
    logic       op;
    logic [7:0] byte_value;
  } in_word_t;

  typedef struct packed {
    logic [3:0] response;
    logic       led_on;
    logic       blinking;
  } out_word_t;

  // what the parser tells the blinker about the current word
  typedef struct packed {
    logic        end_line;
    logic        overflow;
    logic        matched;
    logic [1:0]  word;
    logic        arg_none;
    logic        arg_on;
    logic        arg_off;
    logic        num_pos;
    logic [30:0] num_value;
  } line_evt_t;

  function automatic logic [2:0] cmd_len(input logic [1:0] w);
    logic [2:0] len;
    unique case (w)
      WORD_LED:    len = 3'd3;
      WORD_BLINK:  len = 3'd5;
      WORD_STATUS: len = 3'd6;
      default:     len = 3'd4;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] cmd_char(input logic [1:0] w, input logic [2:0] p);
    logic [47:0] text;
    logic [7:0]  ch;
    unique case (w)
      WORD_LED:    text = {"LED",    24'd0};
      WORD_BLINK:  text = {"BLINK",   8'd0};
      WORD_STATUS: text = "STATUS";
      default:     text = {"HELP",   16'd0};
    endcase
    case (p)
      3'd0:    ch = text[47:40];
      3'd1:    ch = text[39:32];
      3'd2:    ch = text[31:24];
      3'd3:    ch = text[23:16];
      3'd4:    ch = text[15:8];
      3'd5:    ch = text[7:0];
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

endpackage

FILE: hdl/lcib_parser.sv
module lcib_parser #(
  parameter int LINE_CAPACITY = lcib_pkg::LINE_CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  lcib_pkg::in_word_t   word,
  output lcib_pkg::line_evt_t  evt
);
  import lcib_pkg::*;

  localparam int LEN_W = $clog2(LINE_CAPACITY);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_CAPACITY - 1);

  typedef enum logic [6:0] {
    AM_NONE  = 7'b0000001,
    AM_EMPTY = 7'b0000010,
    AM_O     = 7'b0000100,
    AM_ON    = 7'b0001000,
    AM_OF    = 7'b0010000,
    AM_OFF   = 7'b0100000,
    AM_OTHER = 7'b1000000
  } am_t;

  typedef enum logic [6:0] {
    NP_BLANK = 7'b0000001,
    NP_PLUS  = 7'b0000010,
    NP_MINUS = 7'b0000100,
    NP_DIGP  = 7'b0001000,
    NP_DIGN  = 7'b0010000,
    NP_STOPP = 7'b0100000,
    NP_STOPN = 7'b1000000
  } np_t;

  logic [LEN_W-1:0] line_length, line_length_next;
  logic [4:0]       command_match, command_match_next;
  am_t              argument_match, argument_match_next;
  logic [30:0]      number_value, number_value_next;
  np_t              number_phase, number_phase_next;
  logic             line_cut, line_cut_next;

  logic [7:0]  c;
  logic        digit, blank;
  logic [4:0]  cm_feed;
  am_t         am_feed;
  np_t         np_feed;
  logic [30:0] nv_feed;
  logic [34:0] nv_times10;

  assign c     = word.byte_value;
  assign digit = (c >= CH_0) && (c <= CH_9);
  assign blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

  // command word matcher
  always_comb begin
    cm_feed = command_match;
    if (command_match == CM_START) begin
      cm_feed = CM_FAIL;
      for (int i = 0; i < 4; i++) begin
        if (cmd_char(2'(i), 3'd0) == c) cm_feed = {2'(i), 3'd1};
      end
    end else if (command_match != CM_FAIL) begin
      if ((command_match[2:0] < cmd_len(command_match[4:3])) &&
          (cmd_char(command_match[4:3], command_match[2:0]) == c)) begin
        cm_feed = {command_match[4:3], command_match[2:0] + 3'd1};
      end else begin
        cm_feed = CM_FAIL;
      end
    end
  end

  // argument matcher and atoi
  always_comb begin
    unique case (argument_match)
      AM_EMPTY: am_feed = (c == CH_O) ? AM_O : AM_OTHER;
      AM_O:     am_feed = (c == CH_N) ? AM_ON : ((c == CH_F) ? AM_OF : AM_OTHER);
      AM_OF:    am_feed = (c == CH_F) ? AM_OFF : AM_OTHER;
      default:  am_feed = AM_OTHER;
    endcase

    unique case (number_phase) inside
      NP_BLANK: begin
        if (blank)               np_feed = NP_BLANK;
        else if (c == CH_PLUS)   np_feed = NP_PLUS;
        else if (c == CH_MINUS)  np_feed = NP_MINUS;
        else if (digit)          np_feed = NP_DIGP;
        else                     np_feed = NP_STOPP;
      end
      NP_PLUS, NP_DIGP:   np_feed = digit ? NP_DIGP : NP_STOPP;
      NP_MINUS, NP_DIGN:  np_feed = digit ? NP_DIGN : NP_STOPN;
      default:            np_feed = number_phase;
    endcase

    nv_times10 = ({4'd0, number_value} << 3) + ({4'd0, number_value} << 1)
               + {31'd0, c[3:0]};
    nv_feed = number_value;
    if (digit && ((np_feed == NP_DIGP) || (np_feed == NP_DIGN)) &&
        (number_phase != NP_STOPP) && (number_phase != NP_STOPN)) begin
      nv_feed = (nv_times10 > {4'd0, NUM_MAX}) ? NUM_MAX : nv_times10[30:0];
    end
  end

  // line state
  always_comb begin
    line_length_next    = line_length;
    command_match_next  = command_match;
    argument_match_next = argument_match;
    number_value_next   = number_value;
    number_phase_next   = number_phase;
    line_cut_next       = line_cut;
    evt.end_line        = 1'b0;
    evt.overflow        = 1'b0;

    if (!word.op && (c != CH_CR)) begin
      if ((c == CH_LF) || (line_length >= LEN_LAST)) begin
        evt.end_line        = (c == CH_LF);
        evt.overflow        = (c != CH_LF);
        line_length_next    = '0;
        command_match_next  = CM_START;
        argument_match_next = AM_NONE;
        number_value_next   = '0;
        number_phase_next   = NP_BLANK;
        line_cut_next       = 1'b0;
      end else begin
        line_length_next = line_length + LEN_W'(1);
        if (!line_cut) begin
          if (c == CH_NUL) begin
            line_cut_next = 1'b1;
          end else if (argument_match == AM_NONE) begin
            if (c == CH_SPACE) argument_match_next = AM_EMPTY;
            else               command_match_next  = cm_feed;
          end else begin
            argument_match_next = am_feed;
            number_phase_next   = np_feed;
            number_value_next   = nv_feed;
          end
        end
      end
    end

    evt.matched   = (command_match != CM_START) && (command_match != CM_FAIL) &&
                    (command_match[2:0] == cmd_len(command_match[4:3]));
    evt.word      = command_match[4:3];
    evt.arg_none  = (argument_match == AM_NONE);
    evt.arg_on    = (argument_match == AM_ON);
    evt.arg_off   = (argument_match == AM_OFF);
    evt.num_pos   = ((number_phase == NP_DIGP) || (number_phase == NP_STOPP)) &&
                    (number_value != '0);
    evt.num_value = number_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length    <= '0;
      command_match  <= CM_START;
      argument_match <= AM_NONE;
      number_value   <= '0;
      number_phase   <= NP_BLANK;
      line_cut       <= 1'b0;
    end else if (fire) begin
      line_length    <= line_length_next;
      command_match  <= command_match_next;
      argument_match <= argument_match_next;
      number_value   <= number_value_next;
      number_phase   <= number_phase_next;
      line_cut       <= line_cut_next;
    end
  end

endmodule

FILE: hdl/lcib_blinker.sv
module lcib_blinker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic                 tick,
  input  lcib_pkg::line_evt_t  evt,
  input  logic [15:0]          period,
  output lcib_pkg::out_word_t  result
);
  import lcib_pkg::*;

  logic        led_level, led_level_next;
  logic        blink_active, blink_active_next;
  logic [31:0] blink_target, blink_target_next;
  logic [31:0] toggle_count, toggle_count_next;
  logic [15:0] elapsed_ms, elapsed_ms_next;

  logic [15:0] elapsed_inc;
  logic [31:0] toggle_inc;
  logic [3:0]  resp;

  assign elapsed_inc = (elapsed_ms == 16'hffff) ? elapsed_ms : elapsed_ms + 16'd1;
  assign toggle_inc  = toggle_count + 32'd1;

  always_comb begin
    led_level_next    = led_level;
    blink_active_next = blink_active;
    blink_target_next = blink_target;
    toggle_count_next = toggle_count;
    elapsed_ms_next   = elapsed_ms;
    resp              = RESP_NONE;

    if (tick) begin
      if (blink_active) begin
        if (elapsed_inc >= period) begin
          led_level_next    = !led_level;
          elapsed_ms_next   = '0;
          toggle_count_next = toggle_inc;
          if (toggle_inc >= blink_target) begin
            blink_active_next = 1'b0;
            resp              = RESP_BLK_DONE;
          end
        end else begin
          elapsed_ms_next = elapsed_inc;
        end
      end
    end else if (evt.overflow) begin
      resp = RESP_TOO_LONG;
    end else if (evt.end_line) begin
      if (!evt.matched) begin
        resp = RESP_UNKNOWN;
      end else begin
        unique case (evt.word)
          WORD_LED: begin
            if (evt.arg_none) begin
              resp = RESP_LED_MISSING;
            end else if (evt.arg_on || evt.arg_off) begin
              led_level_next    = evt.arg_on;
              blink_active_next = 1'b0;
              resp              = evt.arg_on ? RESP_LED_ON : RESP_LED_OFF;
            end else begin
              resp = RESP_LED_BAD;
            end
          end
          WORD_BLINK: begin
            if (evt.arg_none) begin
              resp = RESP_BLK_MISSING;
            end else if (!evt.num_pos) begin
              resp = RESP_BLK_BAD;
            end else begin
              blink_target_next = {evt.num_value, 1'b0};
              toggle_count_next = '0;
              elapsed_ms_next   = '0;
              blink_active_next = 1'b1;
              resp              = RESP_BLK_START;
            end
          end
          WORD_STATUS: resp = led_level ? RESP_STATUS_ON : RESP_STATUS_OFF;
          default:     resp = RESP_HELP;
        endcase
      end
    end

    result.response = resp;
    result.led_on   = led_level_next;
    result.blinking = blink_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_level    <= 1'b0;
      blink_active <= 1'b0;
      blink_target <= '0;
      toggle_count <= '0;
      elapsed_ms   <= '0;
    end else if (fire) begin
      led_level    <= led_level_next;
      blink_active <= blink_active_next;
      blink_target <= blink_target_next;
      toggle_count <= toggle_count_next;
      elapsed_ms   <= elapsed_ms_next;
    end
  end

endmodule

FILE: hdl/line_command_interpreter_blinker.sv
// Line command interpreter with LED blinker. Each input word is either a
// received text byte (op 0) or a one millisecond tick (op 1), and each one
// gives exactly one result word: a response code plus the LED level and
// blink flag after that word. Lines end at LF, CR is dropped, and the text
// is matched on the fly (LED ON, LED OFF, BLINK n, STATUS, HELP), so no
// line buffer is kept. A line that holds LINE_CAPACITY-1 bytes answers
// "too long" on the next byte other than CR or LF and starts over.
// cfg_write/cfg_data set the blink period in ms (reset 200); write it only
// while no word is in flight.
// Rate: one word per clock while out_stall is low. An accepted word is
// held in the input register; its result is then loaded into the result
// register, where it can be taken.
// in_stall follows out_stall combinationally when both registers are full.
module line_command_interpreter_blinker #(
  parameter int LINE_CAPACITY = lcib_pkg::LINE_CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcib_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lcib_pkg::out_word_t out_data,
  input  logic                cfg_write,
  input  logic [15:0]         cfg_data
);
  import lcib_pkg::*;

  // input register
  logic      in_full;
  in_word_t  in_reg;

  // result register load and the word it processes
  logic      load_out;
  logic      fire;

  logic [15:0] blink_period_ms;
  line_evt_t   evt;
  out_word_t   result;

  assign load_out = !out_valid || !out_stall;
  assign fire     = in_full && load_out;
  assign in_stall = in_full && !load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) in_reg <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_data <= result;
  end

  // period register
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period_ms <= PERIOD_RESET;
    end else if (cfg_write) begin
      blink_period_ms <= cfg_data;
    end
  end

  // line matcher: byte words only
  lcib_parser #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .word (in_reg),
    .evt  (evt)
  );

  // command execution and tick-driven blink sequence
  lcib_blinker u_blinker (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .tick   (in_reg.op),
    .evt    (evt),
    .period (blink_period_ms),
    .result (result)
  );

  // a finished sequence is never reported as still running
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.response == RESP_BLK_DONE) |-> !out_data.blinking)
    else $error("blink done while blinking");

  // a started sequence is running
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.response == RESP_BLK_START) |-> out_data.blinking)
    else $error("blink started but not running");

  // LED ON lights the LED and stops blinking
  a_led_on: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.response == RESP_LED_ON) |->
      out_data.led_on && !out_data.blinking)
    else $error("LED ON result inconsistent");

  // a held result is not dropped by the pipeline
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result lost");

endmodule

FILE: bench/line_command_interpreter_blinker_test.sv
// Bench for the line command interpreter / LED blinker.
// Words go in through a valid/stall driver fed from a queue. Every accepted input
// word runs through a local predictor, which pushes one expected result word.
// The monitor checks result words in order, one field at a time.
// Run order: a directed pass at the reset period, then random passes at blink
// periods 1, 0 and 3, a directed pass at 65535, and a random pass at one random
// small period. The last pass has no idling on either side.
module line_command_interpreter_blinker_test;
  import lcib_pkg::*;

  localparam int WATCHDOG_LIMIT = 400;   // cycles with no word moving on either side
  localparam int DRAIN_CYCLES   = 8;     // idle clocks after the last result has returned

  // argument matcher: tracks ON / OFF after the first space
  typedef enum logic [2:0] {
    ARG_NONE, ARG_EMPTY, ARG_O, ARG_ON, ARG_OF, ARG_OFF, ARG_OTHER
  } arg_e;

  // atoi phases: leading blanks, sign, digits, stopped (positive / negative)
  typedef enum logic [2:0] {
    NP_BLANK, NP_PLUS, NP_MINUS, NP_DIGP, NP_DIGN, NP_STOPP, NP_STOPN
  } num_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = '0;

  always #2 clk = ~clk;

  line_command_interpreter_blinker i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state. Starts at reset values; the period changes only through
  // set_period, and that runs only while nothing is in flight.
  // ---------------------------------------------------------------------------
  logic [15:0] period_ms    = PERIOD_RESET;
  logic        led_lvl      = 1'b0;
  logic        blink_run    = 1'b0;
  logic [31:0] blink_goal   = '0;
  logic [31:0] toggles_done = '0;
  logic [15:0] ms_count     = '0;
  int          line_len     = 0;
  logic [4:0]  cmd_state    = CM_START;
  arg_e        arg_state    = ARG_NONE;
  logic [30:0] num_val      = '0;
  num_e        num_phase    = NP_BLANK;
  logic        text_cut     = 1'b0;    // NUL seen: rest of the line is only counted

  in_word_t  pending_words[$];     // input words not yet presented
  out_word_t awaited_results[$];   // predicted result words, oldest first
  int        queued_count = 0;

  // bench knobs, percent
  int idle_pct  = 20;
  int stall_pct = 20;
  int noise_pct = 0;   // chance of a stray CR or tick before a byte

  logic in_sent = 1'b0;   // input word moved at the last rising edge
  int   in_gap = 0;
  int   stall_gap = 0;
  int   quiet_cycles = 0;
  int   bad_count = 0;

  function automatic string word_text(logic [1:0] w);
    case (w)
      WORD_LED:    return "LED";
      WORD_BLINK:  return "BLINK";
      WORD_STATUS: return "STATUS";
      default:     return "HELP";
    endcase
  endfunction

  function automatic void restart_line();
    line_len  = 0;
    cmd_state = CM_START;
    arg_state = ARG_NONE;
    num_val   = '0;
    num_phase = NP_BLANK;
    text_cut  = 1'b0;
  endfunction

  // One input word in, one result word out; updates the predictor state.
  function automatic out_word_t interpret_word(in_word_t w);
    out_word_t  r;
    logic [3:0] resp;
    logic [7:0] c;
    string      cmd_word;
    logic       word_done;
    logic       digit;
    logic       blank;
    logic [63:0] grown;
    resp = RESP_NONE;
    c = w.byte_value;
    if (w.op) begin
      // tick: only matters while blinking
      if (blink_run) begin
        if (ms_count != 16'hffff) ms_count++;
        if (ms_count >= period_ms) begin
          led_lvl = !led_lvl;
          ms_count = '0;
          toggles_done++;
          if (toggles_done >= blink_goal) begin
            blink_run = 1'b0;
            resp = RESP_BLK_DONE;
          end
        end
      end
    end else if (c == CH_LF) begin
      cmd_word = word_text(cmd_state[4:3]);
      word_done = cmd_state != CM_START && cmd_state != CM_FAIL &&
                  int'(cmd_state[2:0]) == cmd_word.len();
      if (!word_done) begin
        resp = RESP_UNKNOWN;
      end else begin
        case (cmd_state[4:3])
          WORD_LED: begin
            if (arg_state == ARG_NONE) begin
              resp = RESP_LED_MISSING;
            end else if (arg_state == ARG_ON) begin
              led_lvl = 1'b1;
              blink_run = 1'b0;
              resp = RESP_LED_ON;
            end else if (arg_state == ARG_OFF) begin
              led_lvl = 1'b0;
              blink_run = 1'b0;
              resp = RESP_LED_OFF;
            end else begin
              resp = RESP_LED_BAD;
            end
          end
          WORD_BLINK: begin
            if (arg_state == ARG_NONE) begin
              resp = RESP_BLK_MISSING;
            end else if (!(num_phase == NP_DIGP || num_phase == NP_STOPP) || num_val == 0) begin
              resp = RESP_BLK_BAD;
            end else begin
              // restart: count and period start over, LED level kept
              blink_goal = {num_val, 1'b0};
              toggles_done = '0;
              ms_count = '0;
              blink_run = 1'b1;
              resp = RESP_BLK_START;
            end
          end
          WORD_STATUS: resp = led_lvl ? RESP_STATUS_ON : RESP_STATUS_OFF;
          default:     resp = RESP_HELP;
        endcase
      end
      restart_line();
    end else if (c != CH_CR) begin
      if (line_len < LINE_CAPACITY_DEF - 1) begin
        line_len++;
        if (!text_cut) begin
          if (c == CH_NUL) begin
            text_cut = 1'b1;
          end else if (arg_state == ARG_NONE) begin
            if (c == CH_SPACE) begin
              arg_state = ARG_EMPTY;
            end else if (cmd_state == CM_START) begin
              cmd_state = CM_FAIL;
              for (int i = 0; i < 4; i++) begin
                cmd_word = word_text(2'(i));
                if (cmd_word[0] == c) cmd_state = {2'(i), 3'd1};
              end
            end else if (cmd_state != CM_FAIL) begin
              cmd_word = word_text(cmd_state[4:3]);
              if (int'(cmd_state[2:0]) < cmd_word.len() && cmd_word[cmd_state[2:0]] == c)
                cmd_state = cmd_state + 5'd1;
              else
                cmd_state = CM_FAIL;
            end
          end else begin
            // argument: ON/OFF matcher and atoi run side by side
            case (arg_state)
              ARG_EMPTY: arg_state = (c == CH_O) ? ARG_O : ARG_OTHER;
              ARG_O:     arg_state = (c == CH_N) ? ARG_ON : (c == CH_F) ? ARG_OF : ARG_OTHER;
              ARG_OF:    arg_state = (c == CH_F) ? ARG_OFF : ARG_OTHER;
              default:   arg_state = ARG_OTHER;
            endcase
            digit = c >= CH_0 && c <= CH_9;
            blank = c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
            case (num_phase)
              NP_BLANK: num_phase = blank ? NP_BLANK : (c == CH_PLUS) ? NP_PLUS :
                                    (c == CH_MINUS) ? NP_MINUS : digit ? NP_DIGP : NP_STOPP;
              NP_PLUS, NP_DIGP:  num_phase = digit ? NP_DIGP : NP_STOPP;
              NP_MINUS, NP_DIGN: num_phase = digit ? NP_DIGN : NP_STOPN;
              default: ;
            endcase
            if (digit && (num_phase == NP_DIGP || num_phase == NP_DIGN)) begin
              grown = 64'(num_val) * 64'd10 + 64'(c - CH_0);
              num_val = (grown > 64'(NUM_MAX)) ? NUM_MAX : grown[30:0];
            end
          end
        end
      end else begin
        // byte past capacity: dropped, line starts over
        resp = RESP_TOO_LONG;
        restart_line();
      end
    end
    r.response = resp;
    r.led_on   = led_lvl;
    r.blinking = blink_run;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers: all of them only append to pending_words and bump queued_count.
  // ---------------------------------------------------------------------------
  function automatic void push_item(logic op, logic [7:0] v);
    in_word_t w;
    w.op = op;
    w.byte_value = v;
    pending_words.push_back(w);
    queued_count++;
  endfunction

  function automatic void push_ticks(int n);
    repeat (n) push_item(1'b1, 8'($urandom_range(0, 255)));   // byte ignored on ticks
  endfunction

  function automatic void push_byte(logic [7:0] c);
    if ($urandom_range(0, 99) < noise_pct) begin
      if ($urandom_range(0, 1)) push_item(1'b0, CH_CR);
      else push_ticks(1);
    end
    push_item(1'b0, c);
  endfunction

  function automatic void push_text(string s);
    foreach (s[i]) push_byte(s[i]);
  endfunction

  function automatic void push_line(string s);
    push_text(s);
    push_byte(CH_LF);
  endfunction

  // BLINK argument: mostly small good counts, plus atoi corner cases
  function automatic void push_random_number();
    string blanks;
    int    pick;
    blanks = "\011\013\014 ";
    pick = $urandom_range(0, 9);
    case (pick)
      5: begin
        repeat ($urandom_range(1, 3)) push_byte(blanks[$urandom_range(0, 3)]);
        push_byte(CH_PLUS);
        push_text($sformatf("%0d", $urandom_range(1, 3)));
      end
      6: begin
        push_byte(CH_MINUS);
        push_text($sformatf("%0d", $urandom_range(0, 3)));
      end
      7: begin
        case ($urandom_range(0, 2))
          0:       push_text("2147483647");
          1:       push_text("2147483648");
          default: push_text("99999999999");
        endcase
      end
      8: begin
        push_text($sformatf("%0d", $urandom_range(1, 3)));
        push_byte($urandom_range(0, 1) ? CH_SPACE : 8'h78);
        push_text("4");
      end
      9: begin
        case ($urandom_range(0, 2))
          0:       push_text("+-2");
          1:       push_text("x1");
          default: push_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        endcase
      end
      default: push_text($sformatf("%0d", $urandom_range(0, 3)));
    endcase
  endfunction

  function automatic void push_random_line();
    string      w;
    int         pick;
    int         k;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      push_text("LED ON");
    end else if (pick < 22) begin
      push_text("LED OFF");
    end else if (pick < 40) begin
      push_text("BLINK ");
      push_random_number();
    end else if (pick < 48) begin
      push_text("STATUS");
    end else if (pick < 53) begin
      push_text("HELP");
    end else if (pick < 60) begin
      // LED with a missing, partial or garbled argument
      w = "ONF X";
      push_text("LED");
      if ($urandom_range(0, 1)) push_byte(CH_SPACE);
      repeat ($urandom_range(0, 4)) push_byte(w[$urandom_range(0, 4)]);
    end else if (pick < 68) begin
      // near miss on a command word: one letter swapped, or last letter dropped
      w = word_text(2'($urandom_range(0, 3)));
      k = $urandom_range(0, w.len());
      for (int i = 0; i < w.len(); i++) begin
        if (i == k) push_byte(8'($urandom_range(65, 90)));
        else if (!(k == w.len() && i == w.len() - 1)) push_byte(w[i]);
      end
      if ($urandom_range(0, 1)) push_text(" ON");
    end else if (pick < 74) begin
      push_text("BLINK");
      case ($urandom_range(0, 2))
        0:       ;
        1:       push_byte(CH_SPACE);
        default: push_text(" Q");
      endcase
    end else if (pick < 84) begin
      // raw bytes, any value but LF
      repeat ($urandom_range(0, 12)) begin
        c = 8'($urandom_range(0, 255));
        push_byte((c == CH_LF) ? 8'hff : c);
      end
    end else if (pick < 89) begin
      // NUL cuts the text; what follows only counts toward length
      push_text(word_text(2'($urandom_range(0, 3))));
      push_byte(CH_NUL);
      push_text($urandom_range(0, 1) ? " ON" : "X 2");
    end else if (pick < 94) begin
      // lengths around the capacity limit
      repeat ($urandom_range(60, 70)) push_byte(8'($urandom_range(48, 90)));
    end else begin
      repeat ($urandom_range(0, 2)) push_byte(CH_SPACE);
    end
    push_byte(CH_LF);
    pick = $urandom_range(0, 99);
    if (pick >= 85) push_ticks($urandom_range(5, 30));   // long enough to finish short blinks
    else if (pick >= 55) push_ticks($urandom_range(1, 4));
  endfunction

  function automatic void push_random_lines(int budget);
    int stop_at;
    stop_at = queued_count + budget;
    while (queued_count < stop_at) push_random_line();
  endfunction

  // sender holds off until every predicted result has come back
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_period(logic [15:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    period_ms = v;
  endtask

  function automatic void note_failure(string msg);
    bad_count++;
    if (bad_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: everything changes on the falling edge. A held word stays put until
  // it is taken; gaps and output stalls come in bursts set by in_gap and stall_gap.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_sent) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
          if (pending_words.size() != 0) in_gap = $urandom_range(0, 9);
        end
      end
      if (stall_gap != 0) begin
        stall_gap--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_gap = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both handshakes on the rising edge, predicts on input
  // accept, checks on output accept, and runs the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t want;
    out_word_t got;
    logic      out_took;
    if (rst) begin
      in_sent = 1'b0;
    end else begin
      in_sent  = in_valid && !in_stall;
      out_took = out_valid && !out_stall;
      if (in_sent) awaited_results.push_back(interpret_word(in_data));
      if (out_took) begin
        got = out_data;
        if (awaited_results.size() == 0) begin
          note_failure($sformatf("result word with none awaited: resp %0d led %0d blink %0d",
                                 got.response, got.led_on, got.blinking));
        end else begin
          want = awaited_results.pop_front();
          if (got.response !== want.response)
            note_failure($sformatf("response: expected %0d, got %0d",
                                   want.response, got.response));
          if (got.led_on !== want.led_on)
            note_failure($sformatf("led_on: expected %0d, got %0d", want.led_on, got.led_on));
          if (got.blinking !== want.blinking)
            note_failure($sformatf("blinking: expected %0d, got %0d",
                                   want.blinking, got.blinking));
        end
      end
      if (in_sent || out_took) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("line_command_interpreter_blinker verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed pass at the reset period (200 ms)
    push_ticks(2);                 // ticks while idle do nothing
    push_line("HELP");
    push_line("STATUS");
    push_line("LED ON");
    push_line("STATUS");
    push_line("LED OFF");
    push_line("");                 // empty line -> unknown
    push_line("LED");              // no argument
    push_line("LED ");             // empty argument
    push_line("LED OX");
    push_line("BLINK");
    push_line("BLINK ");
    push_line("BLINK 0");
    push_line("BLINK -7");
    push_line("BLINK +");
    push_line("STATUSX");
    push_line("HEL");
    push_text("LED");              // NUL ends the text, so the argument is never seen
    push_byte(CH_NUL);
    push_line(" ON");
    push_text("LED O");            // CRs are dropped mid-line
    push_byte(CH_CR);
    push_text("N");
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(8'hff);
    push_byte(CH_LF);
    push_text("BLINK");            // atoi blanks, sign and trailing junk
    push_byte(CH_SPACE);
    push_byte(CH_TAB);
    push_byte(8'h0b);
    push_byte(8'h0c);
    push_line("+1z");
    push_ticks(400);               // two toggles at 200 ms, then done
    push_line("BLINK 2147483648"); // saturates
    push_ticks(5);
    push_line("BLINK 99999999999");
    push_line("LED ON");           // stops the blink
    repeat (63) push_byte(8'h41);  // exactly fills the line
    push_byte(CH_LF);
    repeat (64) push_byte(8'h42);  // one past: too long, line restarts
    push_byte(CH_LF);
    wait_drained();

    set_period(16'd1);
    idle_pct  = 30;
    stall_pct = 30;
    noise_pct = 5;
    push_random_lines(100);
    wait_drained();

    set_period(16'd0);             // toggles on every tick
    idle_pct  = 0;
    stall_pct = 0;
    push_random_lines(100);
    wait_drained();

    set_period(16'd3);
    idle_pct  = 50;
    stall_pct = 50;
    push_random_lines(60);
    wait_drained();
    push_random_lines(60);
    wait_drained();

    // longest period: ticks keep counting but stay short of a toggle
    set_period(16'hffff);
    idle_pct  = 10;
    stall_pct = 10;
    noise_pct = 0;
    push_line("BLINK 1");
    push_ticks(20);
    push_line("STATUS");
    push_line("LED OFF");
    wait_drained();

    // closing pass, no idling on either side
    set_period(16'($urandom_range(2, 9)));
    idle_pct  = 0;
    stall_pct = 0;
    noise_pct = 5;
    push_random_lines(120);
    wait_drained();

    if (bad_count == 0) begin
      $display("line_command_interpreter_blinker verification clean");
    end else begin
      $display("line_command_interpreter_blinker verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/lcib_pkg.sv
hdl/lcib_parser.sv
hdl/lcib_blinker.sv
hdl/line_command_interpreter_blinker.sv
bench/line_command_interpreter_blinker_test.sv
